>>> hw/rtl/servo_jog_and_preset_positioner_defines.svh
// ----------------------------------------------------------------------------
// Servo positioner assertion macros
// Shared concurrent assertion forms, empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef SERVO_JOG_AND_PRESET_POSITIONER_DEFINES_SVH
`define SERVO_JOG_AND_PRESET_POSITIONER_DEFINES_SVH
`ifndef SYNTHESIS
`define SJPP_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("servo positioner check failed");
`define SJPP_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("servo positioner check failed");
`else
`define SJPP_ASSERT_IMP(lbl, ante, cons)
`define SJPP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hw/rtl/sjpp_pkg.sv
// ----------------------------------------------------------------------------
// Servo positioner package
// Sequencer states, command codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package sjpp_pkg;

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_CMD  = 10'b0000000010,
      ST_RD   = 10'b0000000100,
      ST_CHK  = 10'b0000001000,
      ST_POST = 10'b0000010000,
      ST_DIV  = 10'b0000100000,
      ST_MUL  = 10'b0001000000,
      ST_WR   = 10'b0010000000,
      ST_FIN  = 10'b0100000000,
      ST_SPARE = 10'b1000000000
   } state_type;

   localparam logic [2:0] CMD_JOG     = 3'd0;
   localparam logic [2:0] CMD_BUTTONS = 3'd1;
   localparam logic [2:0] CMD_ADD     = 3'd2;
   localparam logic [2:0] CMD_GOTO    = 3'd3;
   localparam logic [2:0] CMD_FIND    = 3'd4;

   localparam logic [2:0] STS_OK     = 3'd0;
   localparam logic [2:0] STS_DUP_ID = 3'd1;
   localparam logic [2:0] STS_FULL   = 3'd2;
   localparam logic [2:0] STS_NO_ID  = 3'd3;
   localparam logic [2:0] STS_EMPTY  = 3'd4;
   localparam logic [2:0] STS_NO_POS = 3'd5;

   localparam logic [2:0] REG_RANGE_FIRST  = 3'd0;
   localparam logic [2:0] REG_RANGE_SECOND = 3'd1;
   localparam logic [2:0] REG_HOME         = 3'd2;
   localparam logic [2:0] REG_JOG_STEP     = 3'd3;
   localparam logic [2:0] REG_MIRROR       = 3'd4;

endpackage

>>> hw/rtl/sjpp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sjpp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/servo_jog_and_preset_positioner.sv
// ----------------------------------------------------------------------------
// Servo jog and preset positioner
// Jog, preset table and button stepping for a Q8.8 servo target angle.
//
// Channel  Dir  Beat contents
// req      in   tuser: command; tdata: increase, decrease, next, previous, id, position
// rsp      out  tdata: servo, changed, logical, target, found id, status
// csr      in   write enable, register index, write data
//
// Jog and idle commands pass through the command and final states; table
// commands scan the preset RAM one entry at a time through read and check
// states, and an add then runs a divider and a multiply before the write.
// Reset clears the table count, the button latch and the sequencer at once.
// A stalled result holds the sequencer in its final cycle.
// ----------------------------------------------------------------------------
`include "servo_jog_and_preset_positioner_defines.svh"

module servo_jog_and_preset_positioner #(
   parameter int PRESET_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // increase, decrease, next, previous, id[7:0], position[7:0]
   input  logic [2:0]  req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // servo[7:0], changed, logical[7:0], target[15:0],
                                    // found id[7:0], status[2:0]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [16:0] csr_wdata
);

   localparam int AW = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
   localparam int CW = $clog2(PRESET_SLOTS + 1);

   sjpp_pkg::state_type state_ff, state_in;

   logic [7:0]         first_ff, second_ff, home_ff;
   logic signed [16:0] step_ff;
   logic               mirror_ff;

   logic [2:0]  cmd_ff, cmd_in;
   logic        inc_ff, inc_in, dec_ff, dec_in, nxt_ff, nxt_in, prv_ff, prv_in;
   logic [7:0]  id_ff, id_in, pos_ff, pos_in;

   logic [15:0]   target_ff, target_in;
   logic [7:0]    current_ff, current_in;
   logic          latch_ff, latch_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in;

   logic        hit_ff, hit_in;
   logic [7:0]  pick_ff, pick_in, fid_ff, fid_in, first_ang_ff, first_ang_in;
   logic [7:0]  last_ang_ff, last_ang_in;
   logic [2:0]  sts_ff, sts_in;
   logic [7:0]  found_ff, found_in;

   logic [17:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [16:0] dvs_ff, dvs_in;
   logic [3:0]  bit_ff, bit_in;
   logic        neg_ff, neg_in;
   logic [32:0] prod_ff, prod_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   logic          ram_we;
   logic [15:0]   ram_rdata;
   logic [7:0]    lo, hi, rd_id, rd_ang, pclamp, wr_ang;
   logic signed [18:0] jog_sum, lo_fx, hi_fx;
   logic signed [9:0]  num, wr_pos, phys;
   logic [17:0]   trial;
   logic [7:0]    new_cur;
   logic          jog_add;

   function automatic logic [7:0] clamp_deg(input logic signed [9:0] p,
                                            input logic [7:0] l, input logic [7:0] h);
      logic [7:0] r;
      begin
         r = p[7:0];
         if (p < $signed({2'b00, l})) r = l;
         if (p > $signed({2'b00, h})) r = h;
         return r;
      end
   endfunction

   sjpp_ram #(.WIDTH(16), .DEPTH(PRESET_SLOTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata ({id_ff, wr_ang}),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign rd_id  = ram_rdata[15:8];
   assign rd_ang = ram_rdata[7:0];
   assign lo     = (first_ff < second_ff) ? first_ff : second_ff;
   assign hi     = (first_ff < second_ff) ? second_ff : first_ff;
   assign lo_fx  = $signed({3'b000, lo, 8'h00});
   assign hi_fx  = $signed({3'b000, hi, 8'h00});
   assign jog_add = inc_ff ^ mirror_ff;
   assign jog_sum = jog_add ? ($signed({3'b000, target_ff}) + 19'(step_ff))
                            : ($signed({3'b000, target_ff}) - 19'(step_ff));
   assign pclamp = clamp_deg($signed({2'b00, pos_ff}), lo, hi);
   assign num    = $signed({2'b00, pclamp}) - $signed({2'b00, home_ff});
   assign trial  = {rem_ff[16:0], quo_ff[15]};
   assign wr_pos = neg_ff ? ($signed({2'b00, home_ff}) - $signed({2'b00, prod_ff[15:8]}))
                          : ($signed({2'b00, home_ff}) + $signed({2'b00, prod_ff[15:8]}));
   assign wr_ang = clamp_deg(wr_pos, lo, hi);
   assign ram_we = (state_ff == sjpp_pkg::ST_WR);
   assign new_cur = target_ff[15:8];
   assign phys = mirror_ff ? ($signed({2'b00, first_ff}) + $signed({2'b00, second_ff})
                              - $signed({2'b00, new_cur}))
                           : $signed({2'b00, new_cur});

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff; inc_in = inc_ff; dec_in = dec_ff; nxt_in = nxt_ff; prv_in = prv_ff;
      id_in = id_ff; pos_in = pos_ff;
      target_in = target_ff; current_in = current_ff; latch_in = latch_ff;
      count_in = count_ff; idx_in = idx_ff;
      hit_in = hit_ff; pick_in = pick_ff; fid_in = fid_ff;
      first_ang_in = first_ang_ff; last_ang_in = last_ang_ff;
      sts_in = sts_ff; found_in = found_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvs_in = dvs_ff; bit_in = bit_ff; neg_in = neg_ff;
      prod_in = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         sjpp_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               inc_in = req_tdata[0]; dec_in = req_tdata[1];
               nxt_in = req_tdata[2]; prv_in = req_tdata[3];
               id_in = req_tdata[11:4]; pos_in = req_tdata[19:12];
               sts_in = sjpp_pkg::STS_OK; found_in = '0;
               hit_in = 1'b0; idx_in = '0;
               state_in = sjpp_pkg::ST_CMD;
            end
         end
         sjpp_pkg::ST_CMD: begin
            state_in = sjpp_pkg::ST_FIN;
            case (cmd_ff)
               sjpp_pkg::CMD_JOG: begin
                  if (inc_ff || dec_ff) begin
                     if (jog_sum < lo_fx) target_in = lo_fx[15:0];
                     else if (jog_sum > hi_fx) target_in = hi_fx[15:0];
                     else target_in = jog_sum[15:0];
                  end
               end
               sjpp_pkg::CMD_BUTTONS: begin
                  if ((nxt_ff || prv_ff) && !latch_ff) begin
                     latch_in = 1'b1;
                     if (count_ff == '0) sts_in = sjpp_pkg::STS_EMPTY;
                     else state_in = sjpp_pkg::ST_RD;
                  end else if (!nxt_ff && !prv_ff) begin
                     latch_in = 1'b0;
                  end
               end
               sjpp_pkg::CMD_ADD, sjpp_pkg::CMD_GOTO, sjpp_pkg::CMD_FIND: begin
                  state_in = (count_ff == '0) ? sjpp_pkg::ST_POST : sjpp_pkg::ST_RD;
               end
               default: state_in = sjpp_pkg::ST_FIN;
            endcase
         end
         sjpp_pkg::ST_RD: state_in = sjpp_pkg::ST_CHK;
         sjpp_pkg::ST_CHK: begin
            last_ang_in = rd_ang;
            if (idx_ff == '0) first_ang_in = rd_ang;
            case (cmd_ff)
               sjpp_pkg::CMD_BUTTONS: begin
                  if (nxt_ff) begin
                     if (!hit_ff && rd_ang > current_ff) begin
                        hit_in = 1'b1; pick_in = rd_ang;
                     end
                  end else if (rd_ang < current_ff) begin
                     hit_in = 1'b1; pick_in = rd_ang;
                  end
               end
               sjpp_pkg::CMD_FIND: begin
                  if (!hit_ff && rd_ang == pos_ff) begin
                     hit_in = 1'b1; fid_in = rd_id;
                  end
               end
               default: begin
                  if (!hit_ff && rd_id == id_ff) begin
                     hit_in = 1'b1; pick_in = rd_ang;
                  end
               end
            endcase
            idx_in = idx_ff + 1'b1;
            state_in = (idx_in == count_ff) ? sjpp_pkg::ST_POST : sjpp_pkg::ST_RD;
         end
         sjpp_pkg::ST_POST: begin
            state_in = sjpp_pkg::ST_FIN;
            case (cmd_ff)
               sjpp_pkg::CMD_BUTTONS: begin
                  if (hit_ff) target_in = {clamp_deg($signed({2'b00, pick_ff}), lo, hi), 8'h00};
                  else if (nxt_ff)
                     target_in = {clamp_deg($signed({2'b00, first_ang_ff}), lo, hi), 8'h00};
                  else
                     target_in = {clamp_deg($signed({2'b00, last_ang_ff}), lo, hi), 8'h00};
               end
               sjpp_pkg::CMD_GOTO: begin
                  if (hit_ff) target_in = {clamp_deg($signed({2'b00, pick_ff}), lo, hi), 8'h00};
                  else sts_in = sjpp_pkg::STS_NO_ID;
               end
               sjpp_pkg::CMD_FIND: begin
                  if (hit_ff) found_in = fid_ff;
                  else sts_in = sjpp_pkg::STS_NO_POS;
               end
               sjpp_pkg::CMD_ADD: begin
                  if (hit_ff) begin
                     sts_in = sjpp_pkg::STS_DUP_ID;
                  end else if (count_ff >= CW'(PRESET_SLOTS)) begin
                     sts_in = sjpp_pkg::STS_FULL;
                  end else begin
                     neg_in = num[9];
                     dvs_in = step_ff[16] ? 17'(-step_ff) : 17'(step_ff);
                     rem_in = '0;
                     bit_in = '0;
                     if (step_ff == '0) begin
                        quo_in = '0;
                        state_in = sjpp_pkg::ST_MUL;
                     end else begin
                        quo_in = {(num[9] ? 8'(-num) : num[7:0]), 8'h00};
                        state_in = sjpp_pkg::ST_DIV;
                     end
                  end
               end
               default: state_in = sjpp_pkg::ST_FIN;
            endcase
         end
         sjpp_pkg::ST_DIV: begin
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = trial - {1'b0, dvs_ff};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 4'd15) state_in = sjpp_pkg::ST_MUL;
         end
         sjpp_pkg::ST_MUL: begin
            prod_in = quo_ff * dvs_ff;
            state_in = sjpp_pkg::ST_WR;
         end
         sjpp_pkg::ST_WR: begin
            count_in = count_ff + 1'b1;
            state_in = sjpp_pkg::ST_FIN;
         end
         sjpp_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               current_in = new_cur;
               rsp_valid_in = 1'b1;
               rsp_data_in = {4'h0, sts_ff, found_ff, target_ff, new_cur,
                              (new_cur != current_ff),
                              (phys < 0) ? 8'h00 : ((phys > 10'sd255) ? 8'hff : phys[7:0])};
               state_in = sjpp_pkg::ST_IDLE;
            end
         end
         default: state_in = sjpp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sjpp_pkg::ST_IDLE;
         first_ff     <= 8'd0;
         second_ff    <= 8'd180;
         home_ff      <= 8'd0;
         step_ff      <= 17'sd46080;
         mirror_ff    <= 1'b0;
         target_ff    <= '0;
         current_ff   <= '0;
         latch_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         current_ff   <= current_in;
         latch_ff     <= latch_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               sjpp_pkg::REG_RANGE_FIRST:  first_ff  <= csr_wdata[7:0];
               sjpp_pkg::REG_RANGE_SECOND: second_ff <= csr_wdata[7:0];
               sjpp_pkg::REG_HOME:         home_ff   <= csr_wdata[7:0];
               sjpp_pkg::REG_JOG_STEP:     step_ff   <= $signed(csr_wdata);
               sjpp_pkg::REG_MIRROR:       mirror_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; inc_ff <= inc_in; dec_ff <= dec_in; nxt_ff <= nxt_in; prv_ff <= prv_in;
      id_ff <= id_in; pos_ff <= pos_in; idx_ff <= idx_in;
      hit_ff <= hit_in; pick_ff <= pick_in; fid_ff <= fid_in;
      first_ang_ff <= first_ang_in; last_ang_ff <= last_ang_in;
      sts_ff <= sts_in; found_ff <= found_in;
      rem_ff <= rem_in; quo_ff <= quo_in; dvs_ff <= dvs_in; bit_ff <= bit_in; neg_ff <= neg_in;
      prod_ff <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == sjpp_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SJPP_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CW'(PRESET_SLOTS))
   `SJPP_ASSERT_IMP(a_write_room, ram_we, count_ff < CW'(PRESET_SLOTS))
   `SJPP_ASSERT_NXT(a_accept_busy, req_tvalid && req_tready, state_ff != sjpp_pkg::ST_IDLE)
   `SJPP_ASSERT_NXT(a_logical_tracks, state_ff == sjpp_pkg::ST_FIN && (!rsp_valid_ff || rsp_tready), rsp_tdata[16:9] == rsp_tdata[32:25])

endmodule
